>>> design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the frame deframer
// Result codes, parser phases and the entry passed from the parser to the
// output stage through the queue.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int LEN_W   = 63;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_KEY     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_SKIP    = 6'b100000
    } phase_t;

    // one classified result on its way to the output stage
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       hdr;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
        logic [7:0]       key;
        logic             last;
    } entry_t;

endpackage

>>> design/websocket_frame_deframer_core.sv
// the causing byte's entry is written into the queue and then popped into the output register, which drives out_valid
// throughput: one byte per cycle while the queue is not full, set by the parser step and queue push
// the input stalls only while the two-entry queue is full
// reset (rst_n low, asynchronous): parser waits for a first header byte, queue
// and output register empty
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core: client frame deframer top level
// Parser, entry queue and result stage for a byte stream of masked frames.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 result_kind,
    output logic                       final_fragment,
    output logic [2:0]                 reserved_bits,
    output logic [3:0]                 frame_opcode,
    output logic                       is_control,
    output logic [wsfd_pkg::LEN_W-1:0] frame_length,
    output logic [7:0]                 payload_byte,
    output logic                       last_of_frame
);

    logic             fire;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_not_empty;
    wsfd_pkg::entry_t push_entry;
    wsfd_pkg::entry_t q_head;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    wsfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .rx_byte    (rx_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    wsfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    wsfd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .final_fragment (final_fragment),
        .reserved_bits  (reserved_bits),
        .frame_opcode   (frame_opcode),
        .is_control     (is_control),
        .frame_length   (frame_length),
        .payload_byte   (payload_byte),
        .last_of_frame  (last_of_frame)
    );

endmodule

>>> design/wsfd_front.sv
// ----------------------------------------------------------------------------
// wsfd_front: header parser
// Walks the frame header byte by byte, tracks the payload count and key
// position, and pushes one classified entry per result into the queue.
// ----------------------------------------------------------------------------
module wsfd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    output logic              push,
    output wsfd_pkg::entry_t  push_entry
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]                 count_reg, count_next;
    logic [7:0]                 hdr_reg, hdr_next;
    logic                       mask_reg, mask_next;
    logic [wsfd_pkg::LEN_W-1:0] length_reg, length_next;
    logic [wsfd_pkg::LEN_W-1:0] rem_reg, rem_next;
    logic [31:0]                key_reg, key_next;
    logic [1:0]                 kpos_reg, kpos_next;

    logic                       len_done;
    logic                       len_mask;
    logic [wsfd_pkg::LEN_W-1:0] len_val;
    logic                       rem_le1;
    logic [7:0]                 key_byte;

    assign rem_le1 = (rem_reg[wsfd_pkg::LEN_W-1:1] == '0);

    always_comb
    begin
        unique case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        hdr_next    = hdr_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        len_done    = 1'b0;
        len_mask    = mask_reg;
        len_val     = length_reg;
        push        = 1'b0;
        push_entry.kind   = wsfd_pkg::KIND_HEADER;
        push_entry.hdr    = hdr_reg;
        push_entry.length = length_reg;
        push_entry.data   = 8'd0;
        push_entry.key    = 8'd0;
        push_entry.last   = 1'b0;

        if (fire)
        begin
            unique case (phase_reg)
                wsfd_pkg::PH_HDR0:
                begin
                    hdr_next   = rx_byte;
                    phase_next = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1:
                begin
                    mask_next = rx_byte[7];
                    len_mask  = rx_byte[7];
                    if (rx_byte[6:0] == wsfd_pkg::LEN_EXT16 ||
                        rx_byte[6:0] == wsfd_pkg::LEN_EXT64)
                    begin
                        length_next = '0;
                        count_next  = (rx_byte[6:0] == wsfd_pkg::LEN_EXT16) ?
                                      wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                        phase_next  = wsfd_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        len_val  = {{(wsfd_pkg::LEN_W-7){1'b0}}, rx_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    // bits shifted past bit 62 drop out, length taken mod 2^63
                    length_next = {length_reg[wsfd_pkg::LEN_W-9:0], rx_byte};
                    count_next  = count_reg - 4'd1;
                    if (count_reg == 4'd1)
                    begin
                        len_val  = length_next;
                        len_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_KEY:
                begin
                    key_next   = {key_reg[23:0], rx_byte};
                    count_next = count_reg - 4'd1;
                    if (count_reg == 4'd1)
                    begin
                        kpos_next       = 2'd0;
                        push            = 1'b1;
                        push_entry.kind = wsfd_pkg::KIND_HEADER;
                        push_entry.last = (rem_reg == '0);
                        phase_next      = (rem_reg == '0) ? wsfd_pkg::PH_HDR0 :
                                                            wsfd_pkg::PH_PAYLOAD;
                    end
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    kpos_next = kpos_reg + 2'd1;
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
                    end
                    if (rem_le1)
                    begin
                        phase_next = wsfd_pkg::PH_HDR0;
                    end
                    push            = 1'b1;
                    push_entry.kind = wsfd_pkg::KIND_PAYLOAD;
                    push_entry.data = rx_byte;
                    push_entry.key  = key_byte;
                    push_entry.last = rem_le1;
                end
                wsfd_pkg::PH_SKIP:
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
                    end
                    if (rem_le1)
                    begin
                        phase_next = wsfd_pkg::PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = wsfd_pkg::PH_HDR0;
                end
            endcase

            // payload length known: go for the key or flag an unmasked frame
            if (len_done)
            begin
                length_next = len_val;
                rem_next    = len_val;
                if (len_mask)
                begin
                    phase_next = wsfd_pkg::PH_KEY;
                    count_next = wsfd_pkg::KEY_BYTES;
                end
                else
                begin
                    push              = 1'b1;
                    push_entry.kind   = wsfd_pkg::KIND_ERROR;
                    push_entry.length = len_val;
                    push_entry.last   = (len_val == '0);
                    phase_next        = (len_val == '0) ? wsfd_pkg::PH_HDR0 :
                                                          wsfd_pkg::PH_SKIP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsfd_pkg::PH_HDR0;
            count_reg  <= '0;
            hdr_reg    <= '0;
            mask_reg   <= 1'b0;
            length_reg <= '0;
            rem_reg    <= '0;
            key_reg    <= '0;
            kpos_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            hdr_reg    <= hdr_next;
            mask_reg   <= mask_next;
            length_reg <= length_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            kpos_reg   <= kpos_next;
        end
    end

endmodule

>>> design/wsfd_queue.sv
// ----------------------------------------------------------------------------
// wsfd_queue: entry queue
// Short fifo between the parser and the output stage so either side can
// stall without stopping the other.
// ----------------------------------------------------------------------------
module wsfd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsfd_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output wsfd_pkg::entry_t  head
);

    wsfd_pkg::entry_t mem [wsfd_pkg::QDEPTH];

    logic [wsfd_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [wsfd_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [wsfd_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == wsfd_pkg::QCNT_W'(wsfd_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> design/wsfd_back.sv
// ----------------------------------------------------------------------------
// wsfd_back: result stage
// Takes queue entries, unmasks payload bytes, splits out the header fields
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module wsfd_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    input  wsfd_pkg::entry_t           q_head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 result_kind,
    output logic                       final_fragment,
    output logic [2:0]                 reserved_bits,
    output logic [3:0]                 frame_opcode,
    output logic                       is_control,
    output logic [wsfd_pkg::LEN_W-1:0] frame_length,
    output logic [7:0]                 payload_byte,
    output logic                       last_of_frame
);

    logic                       valid_reg, valid_next;
    logic [1:0]                 kind_reg;
    logic                       fin_reg;
    logic [2:0]                 rsv_reg;
    logic [3:0]                 op_reg;
    logic                       ctrl_reg;
    logic [wsfd_pkg::LEN_W-1:0] len_reg;
    logic [7:0]                 data_reg;
    logic                       last_reg;

    assign pop = q_not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= q_head.kind;
            fin_reg  <= q_head.hdr[7];
            rsv_reg  <= q_head.hdr[6:4];
            op_reg   <= q_head.hdr[3:0];
            ctrl_reg <= q_head.hdr[3];
            len_reg  <= q_head.length;
            data_reg <= q_head.data ^ q_head.key;
            last_reg <= q_head.last;
        end
    end

    assign out_valid      = valid_reg;
    assign result_kind    = kind_reg;
    assign final_fragment = fin_reg;
    assign reserved_bits  = rsv_reg;
    assign frame_opcode   = op_reg;
    assign is_control     = ctrl_reg;
    assign frame_length   = len_reg;
    assign payload_byte   = data_reg;
    assign last_of_frame  = last_reg;

endmodule
